### src/scl2x_pkg.sv
`timescale 1ns / 1ps

package scl2x_pkg;

    localparam int PIX_W     = 32;
    localparam int COL_BITS  = 11;
    localparam int ROW_BITS  = 12;
    localparam int CFG_W     = 13;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 152;

    localparam int RESET_WIDTH  = 64;
    localparam int RESET_HEIGHT = 64;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_UP   = 2'd0,
        KIND_LEFT = 2'd1,
        KIND_HERE = 2'd2
    } kind_t;

    typedef struct packed {
        logic has_up;
        logic two_up;
        logic x_ge1;
        logic x_ge2;
        logic right_in;
    } nbr_t;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        nbr_t                nbr;
        logic [2:0]          kinds;
        logic [PIX_W-1:0]    pix_p;
        logic [PIX_W-1:0]    pix_p1;
        logic [PIX_W-1:0]    pix_p2;
        logic [PIX_W-1:0]    pix_e;
        logic [PIX_W-1:0]    pix_b;
        logic [PIX_W-1:0]    pix_d;
        logic [PIX_W-1:0]    pix_f;
    } job_t;

endpackage

### src/scl2x_ram.sv
`timescale 1ns / 1ps

module scl2x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/scl2x_queue.sv
`timescale 1ns / 1ps

module scl2x_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  scl2x_pkg::job_t                din,
    input  logic                           pop,
    output logic                           valid,
    output scl2x_pkg::job_t                head,
    output logic [scl2x_pkg::QCNT_W-1:0]   count
);

    scl2x_pkg::job_t                    slots_reg [scl2x_pkg::QDEPTH];
    logic [scl2x_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [scl2x_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [scl2x_pkg::QCNT_W-1:0]       count_reg, count_next;

    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= din;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = slots_reg[rd_ptr_reg];
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != scl2x_pkg::QCNT_W'(scl2x_pkg::QDEPTH))
        else $error("job queue overflow");

endmodule

### src/scl2x_front.sv
`timescale 1ns / 1ps

module scl2x_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scl2x_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [scl2x_pkg::CFG_W-1:0]       cfg_data,
    input  logic [scl2x_pkg::QCNT_W-1:0]      q_count,
    output logic                              push,
    output scl2x_pkg::job_t                   job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    function automatic logic [CW-1:0] w_last_of(input logic [31:0] v);
        logic [CW-1:0] r;
        if (v == 32'd0)
        begin
            r = '0;
        end
        else if (v > 32'(MAX_WIDTH))
        begin
            r = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            r = CW'(v - 32'd1);
        end
        return r;
    endfunction

    function automatic logic [RW-1:0] h_last_of(input logic [31:0] v);
        logic [RW-1:0] r;
        if (v == 32'd0)
        begin
            r = '0;
        end
        else if (v > 32'(MAX_HEIGHT))
        begin
            r = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            r = RW'(v - 32'd1);
        end
        return r;
    endfunction

    logic                  accept;
    logic                  cfg_wr;
    logic [PIXEL_BITS-1:0] pix;
    logic [PIXEL_BITS-1:0] new_rdata, old_rdata;
    logic [PIXEL_BITS-1:0] cur_new, cur_old;
    logic [CW-1:0]         rd_addr;

    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [CW-1:0]         w_last_reg, w_last_next;
    logic [RW-1:0]         h_last_reg, h_last_next;

    logic                  fwd_reg;
    logic [PIXEL_BITS-1:0] fwd_new_reg, fwd_old_reg;
    logic [PIXEL_BITS-1:0] prev1_reg, prev2_reg, uprev_reg;

    logic                  a_valid_reg;
    logic [CW-1:0]         a_col_reg;
    logic [RW-1:0]         a_row_reg;
    scl2x_pkg::nbr_t       a_nbr_reg;
    logic [2:0]            a_kinds_reg;
    logic [PIXEL_BITS-1:0] a_p_reg, a_p1_reg, a_p2_reg, a_e_reg, a_b_reg, a_d_reg;

    logic                  last_col, last_row;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign s_tready  = (32'(q_count) + 32'(a_valid_reg)) < 32'(scl2x_pkg::QDEPTH);
    assign accept    = s_tvalid && s_tready;
    assign pix       = s_tdata[PIXEL_BITS-1:0];

    assign cur_new  = fwd_reg ? fwd_new_reg : new_rdata;
    assign cur_old  = fwd_reg ? fwd_old_reg : old_rdata;
    assign last_col = (col_reg == w_last_reg);
    assign last_row = (row_reg == h_last_reg);
    assign rd_addr  = last_col ? '0 : col_reg + 1'b1;

    scl2x_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_newer_row (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pix),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (new_rdata)
    );

    scl2x_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_row (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (cur_new),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (old_rdata)
    );

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
            unique case (cfg_index)
                scl2x_pkg::REG_FRAME_WIDTH:  w_last_next = w_last_of(32'(cfg_data[11:0]));
                scl2x_pkg::REG_FRAME_HEIGHT: h_last_next = h_last_of(32'(cfg_data));
                default: ;
            endcase
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            w_last_reg  <= w_last_of(32'(scl2x_pkg::RESET_WIDTH));
            h_last_reg  <= h_last_of(32'(scl2x_pkg::RESET_HEIGHT));
            fwd_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            w_last_reg  <= w_last_next;
            h_last_reg  <= h_last_next;
            a_valid_reg <= accept;
            if (accept)
            begin
                fwd_reg <= (rd_addr == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_new_reg <= pix;
            fwd_old_reg <= cur_new;
            prev1_reg   <= pix;
            prev2_reg   <= prev1_reg;
            uprev_reg   <= cur_new;

            a_col_reg         <= col_reg;
            a_row_reg         <= row_reg;
            a_nbr_reg.has_up  <= (row_reg != '0);
            a_nbr_reg.two_up  <= (row_reg > RW'(1));
            a_nbr_reg.x_ge1   <= (col_reg != '0);
            a_nbr_reg.x_ge2   <= (col_reg > CW'(1));
            a_nbr_reg.right_in <= !last_col;
            a_kinds_reg[scl2x_pkg::KIND_UP]   <= (row_reg != '0);
            a_kinds_reg[scl2x_pkg::KIND_LEFT] <= last_row && (col_reg != '0);
            a_kinds_reg[scl2x_pkg::KIND_HERE] <= last_row && last_col;
            a_p_reg  <= pix;
            a_p1_reg <= prev1_reg;
            a_p2_reg <= prev2_reg;
            a_e_reg  <= cur_new;
            a_b_reg  <= cur_old;
            a_d_reg  <= uprev_reg;
        end
    end

    // right neighbor lands from the look-ahead read in the cycle after the transfer
    always_comb
    begin
        job.col    = scl2x_pkg::COL_BITS'(a_col_reg);
        job.row    = scl2x_pkg::ROW_BITS'(a_row_reg);
        job.nbr    = a_nbr_reg;
        job.kinds  = a_kinds_reg;
        job.pix_p  = scl2x_pkg::PIX_W'(a_p_reg);
        job.pix_p1 = scl2x_pkg::PIX_W'(a_p1_reg);
        job.pix_p2 = scl2x_pkg::PIX_W'(a_p2_reg);
        job.pix_e  = scl2x_pkg::PIX_W'(a_e_reg);
        job.pix_b  = scl2x_pkg::PIX_W'(a_b_reg);
        job.pix_d  = scl2x_pkg::PIX_W'(a_d_reg);
        job.pix_f  = scl2x_pkg::PIX_W'(new_rdata);
    end

    assign push = a_valid_reg && (a_kinds_reg != 3'b000);

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("column counter beyond frame width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_last_reg)
        else $error("row counter beyond frame height");

endmodule

### src/scl2x_back.sv
`timescale 1ns / 1ps

module scl2x_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  scl2x_pkg::job_t                   q_head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scl2x_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int PW = scl2x_pkg::PIX_W;

    logic [2:0]                      sent_reg, sent_next;
    logic                            m_valid_reg, m_valid_next;
    logic [scl2x_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                            m_last_reg, m_last_next;
    logic                            m_user_reg, m_user_next;

    logic [2:0]                      pending, pick_mask, rest;
    scl2x_pkg::kind_t                pick;
    logic                            out_free, emit, last;
    logic [PW-1:0]                   b, d, e, f, h;
    logic [PW-1:0]                   tl, tr, bl, br;
    logic [scl2x_pkg::COL_BITS-1:0]  col;
    logic [scl2x_pkg::ROW_BITS-1:0]  row;
    logic                            done;

    assign out_free = !m_valid_reg || m_tready;
    assign pending  = q_head.kinds & ~sent_reg;

    always_comb
    begin
        if (pending[scl2x_pkg::KIND_UP])
        begin
            pick = scl2x_pkg::KIND_UP;
        end
        else if (pending[scl2x_pkg::KIND_LEFT])
        begin
            pick = scl2x_pkg::KIND_LEFT;
        end
        else
        begin
            pick = scl2x_pkg::KIND_HERE;
        end
    end

    assign pick_mask = 3'b001 << pick;
    assign rest      = pending & ~pick_mask;
    assign last      = (rest == 3'b000);
    assign emit      = q_valid && out_free && (pending != 3'b000);
    assign pop       = emit && last;

    // clamped neighborhood of the chosen centre
    always_comb
    begin
        col  = q_head.col;
        row  = q_head.row;
        done = 1'b0;
        e    = q_head.pix_e;
        b    = q_head.pix_e;
        d    = q_head.pix_e;
        f    = q_head.pix_e;
        h    = q_head.pix_p;
        unique case (pick)
            scl2x_pkg::KIND_UP:
            begin
                row = q_head.row - 1'b1;
                e   = q_head.pix_e;
                b   = q_head.nbr.two_up ? q_head.pix_b : q_head.pix_e;
                d   = q_head.nbr.x_ge1 ? q_head.pix_d : q_head.pix_e;
                f   = q_head.nbr.right_in ? q_head.pix_f : q_head.pix_e;
                h   = q_head.pix_p;
            end
            scl2x_pkg::KIND_LEFT:
            begin
                col = q_head.col - 1'b1;
                e   = q_head.pix_p1;
                b   = q_head.nbr.has_up ? q_head.pix_d : q_head.pix_p1;
                d   = q_head.nbr.x_ge2 ? q_head.pix_p2 : q_head.pix_p1;
                f   = q_head.pix_p;
                h   = q_head.pix_p1;
            end
            scl2x_pkg::KIND_HERE:
            begin
                done = 1'b1;
                e    = q_head.pix_p;
                b    = q_head.nbr.has_up ? q_head.pix_e : q_head.pix_p;
                d    = q_head.nbr.x_ge1 ? q_head.pix_p1 : q_head.pix_p;
                f    = q_head.pix_p;
                h    = q_head.pix_p;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        tl = e;
        tr = e;
        bl = e;
        br = e;
        if (b != h && d != f)
        begin
            tl = (d == b) ? d : e;
            tr = (b == f) ? f : e;
            bl = (d == h) ? d : e;
            br = (h == f) ? f : e;
        end
    end

    always_comb
    begin
        sent_next    = sent_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, br, bl, tr, tl, row, col};
            m_last_next  = last;
            m_user_next  = done;
            sent_next    = last ? 3'b000 : (sent_reg | pick_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg    <= 3'b000;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg    <= sent_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_user_reg |-> m_last_reg)
        else $error("frame end not on the last result of its pixel");

    a_sent_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_valid || ((q_head.kinds != 3'b000) && ((sent_reg & ~q_head.kinds) == 3'b000)))
        && (q_valid || (sent_reg == 3'b000)))
        else $error("result bookkeeping out of step with queue head");

endmodule

### src/pixel_art_scale2x_upscaler.sv
`timescale 1ns / 1ps

// Scale2x pixel-art upscaler. Source pixels enter on s_* in raster order, one transfer
// per pixel, and each source centre leaves on m_* as one transfer carrying its four
// destination pixels. A centre is sent once its lower neighbor has arrived, so a row
// comes out one row late; on the last row each pixel past column 0 sends two results
// (three at the last column). Above the last row the block takes one pixel per clock
// while the job queue has room; on the last row the single output register, one result
// per clock while m_tready is high, sets the pace. The first result of an input transfer
// passes through the front's job registers, the job queue and the output register before
// it is presented on m_*. Two single-port-read row memories of MAX_WIDTH words hold the
// upper rows and need no clearing after reset. Writing either configuration register
// restarts the frame at row 0, column 0; write them only while the block is idle.

module pixel_art_scale2x_upscaler #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scl2x_pkg::IN_DATA_W-1:0]   s_tdata,   // pixel_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // centre_col, centre_row, top_left, top_right, bottom_left, bottom_right, zero pad
    output logic [scl2x_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                              m_tlast,   // last_of_run
    output logic                              m_tuser,   // frame_done
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [scl2x_pkg::CFG_W-1:0]       cfg_data
);

    logic                          push, pop, q_valid;
    scl2x_pkg::job_t               job, q_head;
    logic [scl2x_pkg::QCNT_W-1:0]  q_count;

    scl2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .push      (push),
        .job       (job)
    );

    scl2x_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job),
        .pop   (pop),
        .valid (q_valid),
        .head  (q_head),
        .count (q_count)
    );

    scl2x_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### verif/pixel_art_scale2x_upscaler_tb.sv
`timescale 1ns / 1ps

module pixel_art_scale2x_upscaler_tb;

    localparam int MAX_W = 2048;
    localparam int MAX_H = 4096;

    localparam int ROW_LO = scl2x_pkg::COL_BITS;
    localparam int TL_LO  = ROW_LO + scl2x_pkg::ROW_BITS;
    localparam int TR_LO  = TL_LO + scl2x_pkg::PIX_W;
    localparam int BL_LO  = TR_LO + scl2x_pkg::PIX_W;
    localparam int BR_LO  = BL_LO + scl2x_pkg::PIX_W;

    typedef enum int {
        PIX_NOISE,
        PIX_DUO,
        PIX_TRIO,
        PIX_RAILS
    } pix_mode_t;

    typedef struct {
        logic [scl2x_pkg::COL_BITS-1:0] col;
        logic [scl2x_pkg::ROW_BITS-1:0] row;
        logic [scl2x_pkg::PIX_W-1:0]    tl;
        logic [scl2x_pkg::PIX_W-1:0]    tr;
        logic [scl2x_pkg::PIX_W-1:0]    bl;
        logic [scl2x_pkg::PIX_W-1:0]    br;
        logic                           last;
        logic                           done;
    } quad_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [scl2x_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [scl2x_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic                             cfg_index = scl2x_pkg::REG_FRAME_WIDTH;
    logic [scl2x_pkg::CFG_W-1:0]      cfg_data = '0;

    logic [scl2x_pkg::PIX_W-1:0] pix_q[$];
    quad_t                       quad_q[$];

    // scale2x state: two row stores, raster position and the two recent pixels
    logic [scl2x_pkg::PIX_W-1:0] up_row[MAX_W];
    logic [scl2x_pkg::PIX_W-1:0] cur_row[MAX_W];
    int                          col_pos = 0;
    int                          row_pos = 0;
    logic [scl2x_pkg::PIX_W-1:0] prev_up = '0;
    logic [scl2x_pkg::PIX_W-1:0] prev_pix = '0;
    int                          fw = scl2x_pkg::RESET_WIDTH;
    int                          fh = scl2x_pkg::RESET_HEIGHT;

    logic [scl2x_pkg::PIX_W-1:0] palette[3];
    bit                          calm[2];
    int                          calm_left[2];

    int errors = 0;
    int in_count = 0;
    int src_wait = 0;
    int sink_wait = 0;
    int sink_next;
    int hold_at = -1;
    int hold_left = 0;
    bit hold_done = 1'b0;

    pixel_art_scale2x_upscaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int clamp_size(int v, int cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return v;
    endfunction

    // stretches of back-to-back transfers alternate with random gaps
    function automatic int draw_gap(int side);
        if (calm_left[side] == 0)
        begin
            calm[side] = $urandom_range(0, 2) == 0;
            calm_left[side] = $urandom_range(20, 80);
        end
        calm_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic quad_t make_quad(int x, int y,
                                        logic [scl2x_pkg::PIX_W-1:0] b,
                                        logic [scl2x_pkg::PIX_W-1:0] d,
                                        logic [scl2x_pkg::PIX_W-1:0] e,
                                        logic [scl2x_pkg::PIX_W-1:0] f,
                                        logic [scl2x_pkg::PIX_W-1:0] h,
                                        logic done);
        quad_t q;
        q.col = x[scl2x_pkg::COL_BITS-1:0];
        q.row = y[scl2x_pkg::ROW_BITS-1:0];
        q.tl = e;
        q.tr = e;
        q.bl = e;
        q.br = e;
        if (b != h && d != f)
        begin
            q.tl = (d == b) ? d : e;
            q.tr = (b == f) ? f : e;
            q.bl = (d == h) ? d : e;
            q.br = (h == f) ? f : e;
        end
        q.last = 1'b0;
        q.done = done;
        return q;
    endfunction

    task automatic scale2x_absorb(input logic [scl2x_pkg::PIX_W-1:0] p);
        int                          w;
        int                          h;
        int                          x;
        int                          r;
        logic [scl2x_pkg::PIX_W-1:0] b;
        logic [scl2x_pkg::PIX_W-1:0] d;
        logic [scl2x_pkg::PIX_W-1:0] e;
        logic [scl2x_pkg::PIX_W-1:0] f;
        quad_t                       res[$];
        w = clamp_size(fw, MAX_W);
        h = clamp_size(fh, MAX_H);
        x = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        // centre one row up is complete once its lower neighbor arrives
        if (r >= 1)
        begin
            e = cur_row[x];
            b = (r >= 2) ? up_row[x] : e;
            d = (x > 0) ? prev_up : e;
            f = (x + 1 < w) ? cur_row[x + 1] : e;
            res.push_back(make_quad(x, r - 1, b, d, e, f, p, 1'b0));
        end
        prev_up = cur_row[x];
        up_row[x] = cur_row[x];
        cur_row[x] = p;
        if (r == h - 1)
        begin
            if (x >= 1)
            begin
                e = prev_pix;
                b = (r >= 1) ? up_row[x - 1] : e;
                d = (x >= 2) ? cur_row[x - 2] : e;
                res.push_back(make_quad(x - 1, r, b, d, e, p, e, 1'b0));
            end
            if (x == w - 1)
            begin
                e = p;
                b = (r >= 1) ? up_row[x] : e;
                d = (x >= 1) ? prev_pix : e;
                res.push_back(make_quad(x, r, b, d, e, e, e, 1'b1));
            end
        end
        prev_pix = p;
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = x + 1;
            row_pos = r;
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            quad_q.push_back(res[i]);
    endtask

    task automatic field_cmp(input string name, input logic [scl2x_pkg::PIX_W-1:0] want,
                             input logic [scl2x_pkg::PIX_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic quad_check();
        quad_t want;
        quad_t got;
        got.col = m_tdata[0 +: scl2x_pkg::COL_BITS];
        got.row = m_tdata[ROW_LO +: scl2x_pkg::ROW_BITS];
        got.tl = m_tdata[TL_LO +: scl2x_pkg::PIX_W];
        got.tr = m_tdata[TR_LO +: scl2x_pkg::PIX_W];
        got.bl = m_tdata[BL_LO +: scl2x_pkg::PIX_W];
        got.br = m_tdata[BR_LO +: scl2x_pkg::PIX_W];
        got.last = m_tlast;
        got.done = m_tuser;
        if (quad_q.size() == 0)
        begin
            $display("%0t: result with none pending, expected nothing, actual col %0d row %0d",
                     $time, got.col, got.row);
            errors++;
        end
        else
        begin
            want = quad_q.pop_front();
            field_cmp("centre_col", want.col, got.col);
            field_cmp("centre_row", want.row, got.row);
            field_cmp("top_left", want.tl, got.tl);
            field_cmp("top_right", want.tr, got.tr);
            field_cmp("bottom_left", want.bl, got.bl);
            field_cmp("bottom_right", want.br, got.br);
            field_cmp("last_of_run", want.last, got.last);
            field_cmp("frame_done", want.done, got.done);
        end
    endtask

    // source side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                scale2x_absorb(s_tdata);
                in_count <= in_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_wait > 0)
                begin
                    s_tvalid <= 1'b0;
                    src_wait <= src_wait - 1;
                end
                else if (pix_q.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pix_q.pop_front();
                    src_wait <= draw_gap(0);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (!hold_done && in_count == hold_at)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end
        else
        begin
            sink_next = sink_wait;
            if (m_tvalid && m_tready)
            begin
                quad_check();
                sink_next = draw_gap(1);
            end
            else if (sink_next > 0)
            begin
                sink_next = sink_next - 1;
            end
            sink_wait <= sink_next;
            m_tready <= (sink_next == 0) && (hold_left == 0);
        end
    end

    function automatic logic [scl2x_pkg::PIX_W-1:0] next_pixel(pix_mode_t mode);
        case (mode)
            PIX_NOISE: return $urandom;
            PIX_DUO:   return palette[$urandom_range(0, 1)];
            PIX_TRIO:  return palette[$urandom_range(0, 2)];
            default:   return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    task automatic push_pixels(input int count, input pix_mode_t mode);
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(0, 5))
                0:       palette[i] = 32'h0;
                1:       palette[i] = 32'hFFFF_FFFF;
                default: palette[i] = $urandom;
            endcase
        end
        for (int i = 0; i < count; i++)
            pix_q.push_back(next_pixel(mode));
    endtask

    task automatic wait_drained();
        while (pix_q.size() != 0 || s_tvalid || quad_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [scl2x_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == scl2x_pkg::REG_FRAME_WIDTH)
            fw = val & 13'h0FFF;
        else
            fh = val;
        col_pos = 0;
        row_pos = 0;
        prev_up = '0;
        prev_pix = '0;
    endtask

    initial
    begin
        logic [scl2x_pkg::PIX_W-1:0] chess_pix[9];
        logic [scl2x_pkg::PIX_W-1:0] plus_pix[9];
        int                          rand_items;
        int                          wv;
        int                          hv;
        int                          w;
        int                          h;
        int                          frames;
        pix_mode_t                   mode;
        chess_pix = '{32'h0, 32'hFFFF_FFFF, 32'h0,
                      32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h0, 32'hFFFF_FFFF, 32'h0};
        plus_pix = '{32'h11, 32'h22, 32'h11,
                     32'h22, 32'h22, 32'h22,
                     32'h33, 32'h22, 32'h33};
        rand_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: one row and a bit, then restart by a register write
        push_pixels(scl2x_pkg::RESET_WIDTH + 3, PIX_RAILS);
        wait_drained();

        reg_write(scl2x_pkg::REG_FRAME_WIDTH, 13'd3);
        reg_write(scl2x_pkg::REG_FRAME_HEIGHT, 13'd3);
        foreach (chess_pix[i])
            pix_q.push_back(chess_pix[i]);
        foreach (plus_pix[i])
            pix_q.push_back(plus_pix[i]);
        wait_drained();

        // width 0 and height 0 both act as one: single-pixel frames back to back
        reg_write(scl2x_pkg::REG_FRAME_WIDTH, 13'h1000);
        reg_write(scl2x_pkg::REG_FRAME_HEIGHT, 13'h0000);
        pix_q.push_back(32'hFFFF_FFFF);
        pix_q.push_back(32'h0);
        wait_drained();

        // widest frame, start of its single row
        reg_write(scl2x_pkg::REG_FRAME_WIDTH, 13'h1800);
        hold_at = in_count + 40;
        push_pixels(120, PIX_TRIO);
        wait_drained();

        // tallest frame, one column, height above range, its first rows
        reg_write(scl2x_pkg::REG_FRAME_WIDTH, 13'h1000);
        reg_write(scl2x_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        push_pixels(40, PIX_DUO);
        wait_drained();

        while (rand_items < 200)
        begin
            case ($urandom_range(0, 9))
                0:       wv = 0;
                1:       wv = $urandom_range(9, 40);
                default: wv = $urandom_range(1, 8);
            endcase
            w = clamp_size(wv, MAX_W);
            case ($urandom_range(0, 9))
                0:       hv = 0;
                1:       hv = (w > 8) ? $urandom_range(1, 3) : $urandom_range(9, 20);
                default: hv = $urandom_range(1, 6);
            endcase
            h = clamp_size(hv, MAX_H);
            reg_write(scl2x_pkg::REG_FRAME_WIDTH, 13'(wv | ($urandom_range(0, 1) << 12)));
            reg_write(scl2x_pkg::REG_FRAME_HEIGHT, 13'(hv));
            frames = $urandom_range(1, 3);
            for (int k = 0; k < frames; k++)
            begin
                mode = pix_mode_t'($urandom_range(0, 3));
                push_pixels(w * h, mode);
                rand_items += w * h;
            end
            // cut-off frame, restarted by the next register write
            if ($urandom_range(0, 3) == 0)
            begin
                wv = $urandom_range(1, w * h);
                push_pixels(wv, PIX_TRIO);
                rand_items += wv;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
